// ===== src/bpc_pkg.sv =====
// Shared constants, register indexes and helper functions for the brick pattern classifier.
// No dependencies. Every other file of the block but bpc_class_if imports this package.
`default_nettype none

package bpc_pkg;

    // Brick lengths and gaps are unsigned Q15.16 values held in 31 bits
    localparam int LEN_W          = 31;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = LEN_W;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT = 3'd6;

    typedef logic [LEN_W-1:0] t_len;

    // Turn the remainder of the folded (non-negative) dividend into the floored
    // remainder of the signed value. A zero length yields remainder zero.
    function automatic t_len bpc_fold(input t_len rem, input logic neg, input t_len len);
        t_len v_res;
        if (len == '0) begin
            v_res = '0;
        end else if (neg) begin
            v_res = len - rem - t_len'(1);
        end else begin
            v_res = rem;
        end
        return v_res;
    endfunction

endpackage

`default_nettype wire

// ===== src/bpc_point_if.sv =====
// Point channel: valid/ready handshake carrying the three signed coordinates.
// Depends on bpc_pkg for the default coordinate width.
`default_nettype none

interface bpc_point_if
    import bpc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

`default_nettype wire

// ===== src/bpc_class_if.sv =====
// Classification channel: valid/ready handshake carrying the inside and mortar flags.
// Standalone; no package items used.
`default_nettype none

interface bpc_class_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic in_mortar;

    modport source (output valid, output inside_res, output in_mortar, input ready);
    modport sink   (input valid, input inside_res, input in_mortar, output ready);
endinterface

`default_nettype wire

// ===== src/bpc_div_cell.sv =====
// One restoring division step per lane: shift in a dividend bit, compare, subtract.
// Depends on bpc_pkg (LEN_W). Instantiated in a row by bpc_div_chain.
`default_nettype none

module bpc_div_cell
    import bpc_pkg::*;
#(
    parameter int NL = 1,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [NL-1:0][LEN_W-1:0]   i_len,
    input  wire logic [NL-1:0][LEN_W-1:0]   i_rem,
    input  wire logic [NL-1:0][DW-1:0]      i_dvd,
    input  wire logic [NL-1:0]              i_neg,
    input  wire logic [SW-1:0]              i_side,
    output logic                            o_valid,
    output logic [NL-1:0][LEN_W-1:0]        o_rem,
    output logic [NL-1:0][DW-1:0]           o_dvd,
    output logic [NL-1:0]                   o_neg,
    output logic [NL-1:0]                   o_qbit,
    output logic [SW-1:0]                   o_side
);

    logic                       r_valid;
    logic [NL-1:0][LEN_W-1:0]   r_rem;
    logic [NL-1:0][DW-1:0]      r_dvd;
    logic [NL-1:0]              r_neg;
    logic [NL-1:0]              r_qbit;
    logic [SW-1:0]              r_side;

    logic [NL-1:0][LEN_W-1:0]   n_rem;
    logic [NL-1:0][DW-1:0]      n_dvd;
    logic [NL-1:0]              n_qbit;

    // Bring down the next dividend bit and subtract the divisor where it fits
    always_comb begin
        logic [LEN_W:0] v_trial;
        logic [LEN_W:0] v_diff;
        logic           v_ge;
        for (int l = 0; l < NL; l++) begin
            v_trial   = {i_rem[l], i_dvd[l][DW-1]};
            v_diff    = v_trial - {1'b0, i_len[l]};
            v_ge      = (v_trial >= {1'b0, i_len[l]});
            n_rem[l]  = v_ge ? v_diff[LEN_W-1:0] : v_trial[LEN_W-1:0];
            n_qbit[l] = v_ge;
            n_dvd[l]  = {i_dvd[l][DW-2:0], 1'b0};
        end
    end

    // Advance the beat when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dvd  <= n_dvd;
            r_neg  <= i_neg;
            r_qbit <= n_qbit;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_neg   = r_neg;
    assign o_qbit  = r_qbit;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== src/bpc_div_chain.sv =====
// Row of DW division cells: one dividend bit per cell, remainder handed cell to cell.
// Depends on bpc_pkg and bpc_div_cell.
`default_nettype none

module bpc_div_chain
    import bpc_pkg::*;
#(
    parameter int NL = 1,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [NL-1:0][LEN_W-1:0]   i_len,
    input  wire logic [NL-1:0][DW-1:0]      i_dvd,
    input  wire logic [NL-1:0]              i_neg,
    input  wire logic [SW-1:0]              i_side,
    output logic                            o_valid,
    output logic [NL-1:0][LEN_W-1:0]        o_rem,
    output logic [NL-1:0]                   o_neg,
    output logic [NL-1:0]                   o_qbit,
    output logic [SW-1:0]                   o_side
);

    logic [DW:0]                s_valid;
    logic [NL-1:0][LEN_W-1:0]   s_rem  [DW+1];
    logic [NL-1:0][DW-1:0]      s_dvd  [DW+1];
    logic [NL-1:0]              s_neg  [DW+1];
    logic [SW-1:0]              s_side [DW+1];
    logic [NL-1:0]              s_qbit [DW];

    // Feed the head of the row with a cleared remainder
    assign s_valid[0] = i_valid;
    assign s_rem[0]   = '0;
    assign s_dvd[0]   = i_dvd;
    assign s_neg[0]   = i_neg;
    assign s_side[0]  = i_side;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        bpc_div_cell #(
            .NL (NL),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (s_valid[k]),
            .i_len   (i_len),
            .i_rem   (s_rem[k]),
            .i_dvd   (s_dvd[k]),
            .i_neg   (s_neg[k]),
            .i_side  (s_side[k]),
            .o_valid (s_valid[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_dvd   (s_dvd[k+1]),
            .o_neg   (s_neg[k+1]),
            .o_qbit  (s_qbit[k]),
            .o_side  (s_side[k+1])
        );
    end

    assign o_valid = s_valid[DW];
    assign o_rem   = s_rem[DW];
    assign o_neg   = s_neg[DW];
    assign o_qbit  = s_qbit[DW-1];
    assign o_side  = s_side[DW];

endmodule

`default_nettype wire

// ===== src/brick_pattern_classifier_top.sv =====
// Running-bond brick classifier: config registers, two division rows, fold and compare stages.
// Depends on bpc_pkg, bpc_point_if, bpc_class_if and bpc_div_chain.
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+-----------------------------------
//   i_point   | in  | valid/ready          | coord_x, coord_y, coord_z (signed)
//   o_class   | out | valid/ready          | inside_res, in_mortar
//   i_cfg_*   | in  | i_cfg_we, no stall   | i_cfg_idx, i_cfg_data
//
// Throughput is one point per clock while the output is not stalled. A point passes a y/z row
// of COORD_WIDTH-1 cells, the x row of XW-1 cells (it needs the z row parity first),
// three fold/compare stages and the output register.
// Synchronous reset loads the default brick sizes; no clearing pass is needed.
// When a finished beat is not taken, the next one parks in a skid register and the
// whole pipeline holds with ready low until the output drains.
`default_nettype none

module brick_pattern_classifier_top
    import bpc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    bpc_point_if.sink                   i_point,
    bpc_class_if.source                 o_class,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Shifted x needs room for the half brick on top of the coordinate
    localparam int XW  = ((COORD_WIDTH > LEN_W) ? COORD_WIDTH : LEN_W) + 1;
    localparam int YDW = COORD_WIDTH - 1;
    localparam int XDW = XW - 1;
    localparam t_len LEN_RESET = t_len'(1) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    t_len r_len_x, r_len_y, r_len_z;
    t_len r_gap_x, r_gap_y, r_gap_z;
    logic r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_x <= LEN_RESET;
            r_len_y <= LEN_RESET;
            r_len_z <= LEN_RESET;
            r_gap_x <= '0;
            r_gap_y <= '0;
            r_gap_z <= '0;
            r_sel   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEN_X:  r_len_x <= i_cfg_data;
                REG_LEN_Y:  r_len_y <= i_cfg_data;
                REG_LEN_Z:  r_len_z <= i_cfg_data;
                REG_GAP_X:  r_gap_x <= i_cfg_data;
                REG_GAP_Y:  r_gap_y <= i_cfg_data;
                REG_GAP_Z:  r_gap_z <= i_cfg_data;
                REG_SELECT: r_sel   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic r_out_valid, r_skid_valid;
    logic w_en, w_out_fire, w_in_fire;

    assign w_en          = !r_skid_valid;
    assign i_point.ready = w_en;
    assign w_in_fire     = i_point.valid && w_en;
    assign w_out_fire    = r_out_valid && o_class.ready;

    // ---------------- y/z division row ----------------
    logic [1:0][YDW-1:0]    w_yz_dvd;
    logic [1:0]             w_yz_neg;
    logic [1:0][LEN_W-1:0]  w_yz_len;

    // Fold negative coordinates to their one's complement, lane 0 is y, lane 1 is z
    always_comb begin
        w_yz_neg[0] = i_point.coord_y[COORD_WIDTH-1];
        w_yz_neg[1] = i_point.coord_z[COORD_WIDTH-1];
        w_yz_dvd[0] = w_yz_neg[0] ? ~i_point.coord_y[YDW-1:0] : i_point.coord_y[YDW-1:0];
        w_yz_dvd[1] = w_yz_neg[1] ? ~i_point.coord_z[YDW-1:0] : i_point.coord_z[YDW-1:0];
        w_yz_len[0] = r_len_y;
        w_yz_len[1] = r_len_z;
    end

    logic                           w_yz_valid;
    logic [1:0][LEN_W-1:0]          w_yz_rem;
    logic [1:0]                     w_yz_neg_o;
    logic [1:0]                     w_yz_qbit;
    logic [COORD_WIDTH-1:0]         w_yz_x;

    bpc_div_chain #(
        .NL (2),
        .DW (YDW),
        .SW (COORD_WIDTH)
    ) u_yz_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_in_fire),
        .i_len   (w_yz_len),
        .i_dvd   (w_yz_dvd),
        .i_neg   (w_yz_neg),
        .i_side  (i_point.coord_x),
        .o_valid (w_yz_valid),
        .o_rem   (w_yz_rem),
        .o_neg   (w_yz_neg_o),
        .o_qbit  (w_yz_qbit),
        .o_side  (w_yz_x)
    );

    // ---------------- stage 1: fold y/z, shift x on even z rows ----------------
    logic                    r_m1_valid;
    t_len                    r_m1_ry, r_m1_rz;
    logic signed [XW-1:0]    r_m1_xs;
    logic                    w_z_odd;
    logic [XW-1:0]           w_x_ext;
    logic [XW-1:0]           w_half;

    assign w_z_odd = (r_len_z != '0) && (w_yz_qbit[1] ^ w_yz_neg_o[1]);
    assign w_x_ext = {{(XW-COORD_WIDTH){w_yz_x[COORD_WIDTH-1]}}, w_yz_x};
    assign w_half  = w_z_odd ? '0 : XW'(r_len_x >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_en) begin
            r_m1_valid <= w_yz_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_ry <= bpc_fold(w_yz_rem[0], w_yz_neg_o[0], r_len_y);
            r_m1_rz <= bpc_fold(w_yz_rem[1], w_yz_neg_o[1], r_len_z);
            r_m1_xs <= w_x_ext + w_half;
        end
    end

    // ---------------- stage 2: y/z gap compare, fold x ----------------
    logic               r_m2_valid;
    logic               r_m2_yz;
    logic               r_m2_neg;
    logic [XDW-1:0]     r_m2_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_en) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_yz  <= (r_m1_ry <= r_gap_y) || (r_m1_rz <= r_gap_z);
            r_m2_neg <= r_m1_xs[XW-1];
            r_m2_dvd <= r_m1_xs[XW-1] ? ~r_m1_xs[XDW-1:0] : r_m1_xs[XDW-1:0];
        end
    end

    // ---------------- x division row ----------------
    logic                   w_x_valid;
    logic [0:0][LEN_W-1:0]  w_x_rem;
    logic [0:0]             w_x_neg;
    logic [0:0]             w_x_qbit;
    logic [0:0]             w_x_yz;

    bpc_div_chain #(
        .NL (1),
        .DW (XDW),
        .SW (1)
    ) u_x_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m2_valid),
        .i_len   (r_len_x),
        .i_dvd   (r_m2_dvd),
        .i_neg   (r_m2_neg),
        .i_side  (r_m2_yz),
        .o_valid (w_x_valid),
        .o_rem   (w_x_rem),
        .o_neg   (w_x_neg),
        .o_qbit  (w_x_qbit),
        .o_side  (w_x_yz)
    );

    // ---------------- stage 3: fold x ----------------
    logic   r_m3_valid;
    t_len   r_m3_rx;
    logic   r_m3_yz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (w_en) begin
            r_m3_valid <= w_x_valid;
        end
    end

    // Hold the floored x remainder beside the y/z verdict
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3_rx <= bpc_fold(w_x_rem[0], w_x_neg[0], r_len_x);
            r_m3_yz <= w_x_yz[0];
        end
    end

    // Final classification beat
    logic w_t_mortar, w_t_inside;

    assign w_t_mortar = r_m3_yz || (r_m3_rx <= r_gap_x);
    assign w_t_inside = w_t_mortar ^ r_sel;

    // ---------------- output register and skid ----------------
    logic r_out_inside, r_out_mortar;
    logic r_skid_inside, r_skid_mortar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_m3_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_inside <= r_skid_inside;
                r_out_mortar <= r_skid_mortar;
            end
        end else if (r_m3_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_inside <= w_t_inside;
                r_out_mortar <= w_t_mortar;
            end else begin
                r_skid_inside <= w_t_inside;
                r_skid_mortar <= w_t_mortar;
            end
        end
    end

    assign o_class.valid      = r_out_valid;
    assign o_class.inside_res = r_out_inside;
    assign o_class.in_mortar  = r_out_mortar;

    // ---------------- assertions ----------------
    // A parked beat implies the output register is full
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the output register is empty");

    // A parked beat stays until the output drains
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_class.ready) |=> r_skid_valid)
        else $error("skid beat lost while output stalled");

    // A zero brick height puts every point in mortar
    a_zero_len_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_len_y == '0) && $stable(r_len_y)) |-> r_out_mortar)
        else $error("zero brick height gave a point outside mortar");

    // A zero brick length along x leaves no x remainder
    a_zero_len_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m3_valid && (r_len_x == '0)) |-> (r_m3_rx == '0))
        else $error("zero brick length left a nonzero x remainder");

endmodule

`default_nettype wire
